### rtl/core/tidw_pkg.sv
// package for the tomasulo issue, dispatch and write-back block: sizes, codes and types
package tidw_pkg;

  localparam int ADD_STATIONS = 3;
  localparam int MUL_STATIONS = 2;
  localparam int TOTAL_STATIONS = ADD_STATIONS + MUL_STATIONS;
  localparam int NUM_REGS = 5;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [1:0] REG_ADD_LAT = 2'd0;
  localparam logic [1:0] REG_MUL_LAT = 2'd1;
  localparam logic [1:0] REG_DIV_LAT = 2'd2;

  typedef struct packed {
    logic        busy;
    logic [1:0]  op;
    logic [31:0] opa;
    logic [31:0] opb;
    logic        rdya;
    logic        rdyb;
    logic [2:0]  waita;
    logic [2:0]  waitb;
    logic [2:0]  dest;
  } station_t;

  typedef struct packed {
    logic        full;
    logic [7:0]  count;
    logic [2:0]  station;
    logic [31:0] value;
  } unit_t;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_WB    = 7'b0000010,
    ST_DISP  = 7'b0000100,
    ST_MUL   = 7'b0001000,
    ST_DIV   = 7'b0010000,
    ST_ISSUE = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

endpackage

### rtl/core/tomasulo_issue_dispatch_writeback.sv
// top level of the tomasulo issue, dispatch and write-back block
// One transaction is one machine tick. busy stays high from the write-back state through the
// done state; done pulses in the cycle after, so a new tick may start while done is high; a
// dispatched divide adds ST_DIV, since the quotient comes from a shared one-bit-per-cycle
// restoring divider, and a dispatched multiply adds ST_MUL for its registered product.
// Results stay on the write-back outputs until the next tick starts and cannot be held off.
module tomasulo_issue_dispatch_writeback (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  output logic        done,
  input  logic        inst_valid,
  input  logic [1:0]  op,
  input  logic [2:0]  dest_reg,
  input  logic [2:0]  src1_reg,
  input  logic [2:0]  src2_reg,
  input  logic        use_imm,
  input  logic [3:0]  immediate,
  output logic        issued,
  output logic        add_wb_valid,
  output logic [2:0]  add_wb_reg,
  output logic signed [31:0] add_wb_value,
  output logic        mul_wb_valid,
  output logic [2:0]  mul_wb_reg,
  output logic signed [31:0] mul_wb_value,
  output logic        all_idle,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NS = tidw_pkg::TOTAL_STATIONS;
  localparam int NR = tidw_pkg::NUM_REGS;
  localparam int AS = tidw_pkg::ADD_STATIONS;

  tidw_pkg::state_t state;
  tidw_pkg::station_t stn [NS];
  tidw_pkg::unit_t unt [2];
  logic [31:0] reg_values [NR+1];
  logic [2:0]  reg_alias [NR+1];
  logic [7:0] add_latency, mul_latency, div_latency;

  logic       t_valid, t_imm;
  logic [1:0] t_op;
  logic [2:0] t_dst, t_s1, t_s2;
  logic [3:0] t_immv;

  logic [31:0] prod;
  logic        dsel;
  logic [31:0] dqa, dqb, drem, dquo;
  logic        dneg;
  logic [5:0]  dcnt;

  logic [1:0] pa;
  assign pa = paddr[3:2];
  assign pready = 1'b1;
  assign busy = (state != tidw_pkg::ST_IDLE);

  always_comb begin
    unique case (pa)
      tidw_pkg::REG_ADD_LAT: prdata = {24'd0, add_latency};
      tidw_pkg::REG_MUL_LAT: prdata = {24'd0, mul_latency};
      tidw_pkg::REG_DIV_LAT: prdata = {24'd0, div_latency};
      default: prdata = 32'd0;
    endcase
  end

  // dispatch selection, one class per cycle in ST_DISP (dsel picks class)
  logic       dfound;
  logic [2:0] dpick;
  always_comb begin
    dfound = 1'b0;
    dpick = 3'd0;
    for (int i = NS - 1; i >= 0; i--) begin
      if ((dsel ? (i >= AS) : (i < AS)) && stn[i].busy && stn[i].rdya && stn[i].rdyb) begin
        dfound = 1'b1;
        dpick = 3'(i);
      end
    end
  end

  // issue selection
  logic       ifound;
  logic [2:0] ipick;
  logic       icls;
  assign icls = t_op[1];
  always_comb begin
    ifound = 1'b0;
    ipick = 3'd0;
    for (int i = NS - 1; i >= 0; i--) begin
      if ((icls ? (i >= AS) : (i < AS)) && !stn[i].busy) begin
        ifound = 1'b1;
        ipick = 3'(i);
      end
    end
  end

  logic any_busy;
  always_comb begin
    any_busy = 1'b0;
    for (int i = 0; i < NS; i++) any_busy = any_busy | stn[i].busy;
  end

  logic wbu;
  logic [31:0] s1v, s2v;
  logic [2:0] s1w, s2w;
  logic s1r, s2r;
  always_comb begin
    if (t_s1 == 3'd0 || t_s1 > 3'(NR)) begin
      s1v = 32'd0; s1r = 1'b1; s1w = 3'd0;
    end else if (reg_alias[t_s1] != 3'd0) begin
      s1v = 32'd0; s1r = 1'b0; s1w = reg_alias[t_s1];
    end else begin
      s1v = reg_values[t_s1]; s1r = 1'b1; s1w = 3'd0;
    end
    if (t_imm) begin
      s2v = {28'd0, t_immv}; s2r = 1'b1; s2w = 3'd0;
    end else if (t_s2 == 3'd0 || t_s2 > 3'(NR)) begin
      s2v = 32'd0; s2r = 1'b1; s2w = 3'd0;
    end else if (reg_alias[t_s2] != 3'd0) begin
      s2v = 32'd0; s2r = 1'b0; s2w = reg_alias[t_s2];
    end else begin
      s2v = reg_values[t_s2]; s2r = 1'b1; s2w = 3'd0;
    end
  end

  logic [32:0] dtrial;
  assign dtrial = {drem, dqa[31]} - {1'b0, dqb};

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      state <= tidw_pkg::ST_IDLE;
      add_latency <= 8'd1;
      mul_latency <= 8'd9;
      div_latency <= 8'd39;
      for (int k = 0; k <= NR; k++) begin
        reg_values[k] <= (k == 0) ? 32'd0 : 32'(2 * (k - 1));
        reg_alias[k] <= 3'd0;
      end
      for (int i = 0; i < NS; i++) stn[i] <= '0;
      unt[0] <= '0;
      unt[1] <= '0;
      wbu <= 1'b0;
      dsel <= 1'b0;
      dcnt <= 6'd0;
    end else begin
      done <= (state == tidw_pkg::ST_DONE);
      if (psel && penable && pwrite) begin
        unique case (pa)
          tidw_pkg::REG_ADD_LAT: add_latency <= pwdata[7:0];
          tidw_pkg::REG_MUL_LAT: mul_latency <= pwdata[7:0];
          tidw_pkg::REG_DIV_LAT: div_latency <= pwdata[7:0];
          default: ;
        endcase
      end
      unique case (state)
        tidw_pkg::ST_IDLE: begin
          if (start) begin
            t_valid <= inst_valid; t_op <= op; t_dst <= dest_reg;
            t_s1 <= src1_reg; t_s2 <= src2_reg; t_imm <= use_imm; t_immv <= immediate;
            wbu <= 1'b0;
            add_wb_valid <= 1'b0; add_wb_reg <= 3'd0; add_wb_value <= 32'sd0;
            mul_wb_valid <= 1'b0; mul_wb_reg <= 3'd0; mul_wb_value <= 32'sd0;
            state <= tidw_pkg::ST_WB;
          end
        end
        tidw_pkg::ST_WB: begin
          // one unit per cycle, add then mul
          if (unt[wbu].full && unt[wbu].count != 8'd0) begin
            unt[wbu].count <= unt[wbu].count - 8'd1;
          end else if (unt[wbu].full) begin
            for (int k = 1; k <= NR; k++) begin
              if (reg_alias[k] == unt[wbu].station + 3'd1) begin
                reg_alias[k] <= 3'd0;
                reg_values[k] <= unt[wbu].value;
              end
            end
            for (int i = 0; i < NS; i++) begin
              if (3'(i) == unt[wbu].station) stn[i] <= '0;
              else if (stn[i].busy) begin
                if (stn[i].waita == unt[wbu].station + 3'd1) begin
                  stn[i].opa <= unt[wbu].value; stn[i].rdya <= 1'b1; stn[i].waita <= 3'd0;
                end
                if (stn[i].waitb == unt[wbu].station + 3'd1) begin
                  stn[i].opb <= unt[wbu].value; stn[i].rdyb <= 1'b1; stn[i].waitb <= 3'd0;
                end
              end
            end
            if (wbu) begin
              mul_wb_valid <= 1'b1;
              mul_wb_reg <= stn[unt[1].station].dest;
              mul_wb_value <= unt[1].value;
            end else begin
              add_wb_valid <= 1'b1;
              add_wb_reg <= stn[unt[0].station].dest;
              add_wb_value <= unt[0].value;
            end
            unt[wbu] <= '0;
          end
          wbu <= ~wbu;
          if (wbu) begin
            dsel <= 1'b0;
            state <= tidw_pkg::ST_DISP;
          end
        end
        tidw_pkg::ST_DISP: begin
          dsel <= ~dsel;
          if (!unt[dsel].full && dfound) begin
            unt[dsel].full <= 1'b1;
            unt[dsel].station <= dpick;
            unique case (stn[dpick].op)
              tidw_pkg::OP_ADD: begin
                unt[dsel].value <= stn[dpick].opa + stn[dpick].opb;
                unt[dsel].count <= add_latency;
                if (dsel) state <= tidw_pkg::ST_ISSUE;
              end
              tidw_pkg::OP_SUB: begin
                unt[dsel].value <= stn[dpick].opa - stn[dpick].opb;
                unt[dsel].count <= add_latency;
                if (dsel) state <= tidw_pkg::ST_ISSUE;
              end
              tidw_pkg::OP_MUL: begin
                prod <= stn[dpick].opa * stn[dpick].opb;
                unt[dsel].count <= mul_latency;
                state <= tidw_pkg::ST_MUL;
              end
              default: begin
                unt[dsel].count <= div_latency;
                dqa <= stn[dpick].opa[31] ? 32'd0 - stn[dpick].opa : stn[dpick].opa;
                dqb <= stn[dpick].opb[31] ? 32'd0 - stn[dpick].opb : stn[dpick].opb;
                dneg <= stn[dpick].opa[31] ^ stn[dpick].opb[31];
                drem <= 32'd0;
                dquo <= 32'd0;
                dcnt <= 6'd0;
                state <= tidw_pkg::ST_DIV;
              end
            endcase
          end else if (dsel) begin
            state <= tidw_pkg::ST_ISSUE;
          end
        end
        tidw_pkg::ST_MUL: begin
          unt[1].value <= prod;
          state <= tidw_pkg::ST_ISSUE;
        end
        tidw_pkg::ST_DIV: begin
          if (dcnt == 6'd32) begin
            if (dqb == 32'd0) unt[1].value <= 32'hFFFF_FFFF;
            else unt[1].value <= dneg ? 32'd0 - dquo : dquo;
            state <= tidw_pkg::ST_ISSUE;
          end else begin
            if (!dtrial[32]) begin
              drem <= dtrial[31:0];
              dquo <= {dquo[30:0], 1'b1};
            end else begin
              drem <= {drem[30:0], dqa[31]};
              dquo <= {dquo[30:0], 1'b0};
            end
            dqa <= {dqa[30:0], 1'b0};
            dcnt <= dcnt + 6'd1;
          end
        end
        tidw_pkg::ST_ISSUE: begin
          issued <= t_valid && ifound;
          if (t_valid && ifound) begin
            stn[ipick].busy <= 1'b1;
            stn[ipick].op <= t_op;
            stn[ipick].opa <= s1v; stn[ipick].rdya <= s1r; stn[ipick].waita <= s1w;
            stn[ipick].opb <= s2v; stn[ipick].rdyb <= s2r; stn[ipick].waitb <= s2w;
            if (t_dst != 3'd0 && t_dst <= 3'(NR)) begin
              stn[ipick].dest <= t_dst;
              reg_alias[t_dst] <= ipick + 3'd1;
            end else begin
              stn[ipick].dest <= 3'd0;
            end
          end
          state <= tidw_pkg::ST_DONE;
        end
        tidw_pkg::ST_DONE: begin
          all_idle <= ~any_busy;
          state <= tidw_pkg::ST_IDLE;
        end
        default: state <= tidw_pkg::ST_IDLE;
      endcase
    end
  end

  a_done_from_done_state: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == tidw_pkg::ST_DONE) else $error("done without finishing tick");
  a_start_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("tick not started");
  a_div_bounded: assert property (@(posedge clk) disable iff (rst)
    state == tidw_pkg::ST_DIV |-> dcnt <= 6'd32) else $error("divider overrun");

endmodule
